// ===== src/xsr_pkg.sv =====
// Shared types and constants for the xoshiro256++ generator.
`default_nettype none
package xsr_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_ONE  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_TWO  = 64'h94D049BB133111EB;
    localparam int unsigned FRACTION_SHIFT = 40;

    localparam logic [1:0] REQ_RAW     = 2'd0;
    localparam logic [1:0] REQ_BOUNDED = 2'd1;
    localparam logic [1:0] REQ_FRAC    = 2'd2;

    typedef enum logic [3:0] {
        ST_SEED,
        ST_EXP_ADD,
        ST_MUL1,
        ST_EXP_X2,
        ST_MUL2,
        ST_EXP_STORE,
        ST_EXP_FIX,
        ST_IDLE,
        ST_DECIDE,
        ST_DRAW,
        ST_DISC_START,
        ST_DISC_RUN,
        ST_BDRAW,
        ST_BCHECK,
        ST_MOD_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEED_LOAD,
        OP_EXP_ADD,
        OP_MUL1,
        OP_EXP_X2,
        OP_MUL2,
        OP_EXP_STORE,
        OP_EXP_FIX,
        OP_LATCH,
        OP_DRAW,
        OP_DIV_DISC,
        OP_DIV_MOD,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] chunk;
        logic [1:0] word_sel;
        logic       seed_we;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       full;
        logic       below;
    } status_t;

endpackage
`default_nettype wire

// ===== src/xsr_dp.sv =====
// Datapath: state words, seed expansion, draw logic and bit-serial remainder unit.
`default_nettype none
module xsr_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire xsr_pkg::cmd_t  cmd,
    input  wire logic [63:0]    seed,
    input  wire logic [1:0]     req_type,
    input  wire logic [63:0]    range_min,
    input  wire logic [63:0]    range_max,
    output xsr_pkg::status_t    status,
    output logic [63:0]         value,
    output logic                bad_range
);

    logic [63:0] seed_reg;
    logic [63:0] x_reg, z_reg, acc_reg;
    logic [63:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] r_reg, rem_reg, dvd_reg;
    logic [63:0] lo_reg, width_reg;
    logic [1:0]  kind_reg;
    logic        empty_reg;
    logic [63:0] value_reg;
    logic        bad_reg;

    logic [63:0] x_sum, mul_const, acc_fin, draw_res, rot_in, t_word;
    logic [63:0] c1, d1, b1, a1;
    logic [79:0] prod;
    logic [64:0] rem_sh;
    logic [5:0]  shamt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cmd.seed_we)
        begin
            seed_reg <= seed;
        end
    end

    always_comb
    begin
        x_sum     = x_reg + xsr_pkg::GOLDEN_GAMMA;
        mul_const = (cmd.op == xsr_pkg::OP_MUL1) ? xsr_pkg::MIX_MUL_ONE : xsr_pkg::MIX_MUL_TWO;
        prod      = z_reg * mul_const[{cmd.chunk, 4'b0000} +: 16];
        shamt     = {cmd.chunk, 4'b0000};
        acc_fin   = acc_reg ^ (acc_reg >> 31);
        rot_in    = a_reg + d_reg;
        draw_res  = {rot_in[40:0], rot_in[63:41]} + a_reg;
        t_word    = b_reg << 17;
        c1        = c_reg ^ a_reg;
        d1        = d_reg ^ b_reg;
        b1        = b_reg ^ c1;
        a1        = a_reg ^ d1;
        rem_sh    = {rem_reg, dvd_reg[63]};
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            xsr_pkg::OP_SEED_LOAD:
            begin
                x_reg <= seed_reg;
            end
            xsr_pkg::OP_EXP_ADD:
            begin
                x_reg   <= x_sum;
                z_reg   <= x_sum ^ (x_sum >> 30);
                acc_reg <= '0;
            end
            xsr_pkg::OP_MUL1, xsr_pkg::OP_MUL2:
            begin
                acc_reg <= acc_reg + (prod[63:0] << shamt);
            end
            xsr_pkg::OP_EXP_X2:
            begin
                z_reg   <= acc_reg ^ (acc_reg >> 27);
                acc_reg <= '0;
            end
            xsr_pkg::OP_EXP_STORE:
            begin
                unique case (cmd.word_sel)
                    2'd0: a_reg <= acc_fin;
                    2'd1: b_reg <= acc_fin;
                    2'd2: c_reg <= acc_fin;
                    default: d_reg <= acc_fin;
                endcase
            end
            xsr_pkg::OP_EXP_FIX:
            begin
                if ((a_reg | b_reg | c_reg | d_reg) == 64'd0)
                begin
                    a_reg <= 64'd1;
                end
            end
            xsr_pkg::OP_LATCH:
            begin
                kind_reg  <= req_type;
                lo_reg    <= range_min;
                width_reg <= range_max - range_min + 64'd1;
                empty_reg <= (range_max <= range_min);
            end
            xsr_pkg::OP_DRAW:
            begin
                r_reg <= draw_res;
                a_reg <= a1;
                b_reg <= b1;
                c_reg <= c1 ^ t_word;
                d_reg <= {d1[18:0], d1[63:19]};
            end
            xsr_pkg::OP_DIV_DISC:
            begin
                rem_reg <= '0;
                dvd_reg <= 64'd0 - width_reg;
            end
            xsr_pkg::OP_DIV_MOD:
            begin
                // The discard bound in rem_reg is no longer needed once a draw is accepted.
                rem_reg  <= '0;
                dvd_reg  <= r_reg;
            end
            xsr_pkg::OP_DIV_STEP:
            begin
                // Restoring remainder step, one dividend bit per cycle.
                if (rem_sh >= {1'b0, width_reg})
                begin
                    rem_reg <= 64'(rem_sh - {1'b0, width_reg});
                end
                else
                begin
                    rem_reg <= rem_sh[63:0];
                end
                dvd_reg <= dvd_reg << 1;
            end
            xsr_pkg::OP_FINISH:
            begin
                bad_reg <= 1'b0;
                if (kind_reg == xsr_pkg::REQ_BOUNDED)
                begin
                    if (empty_reg)
                    begin
                        value_reg <= '0;
                        bad_reg   <= 1'b1;
                    end
                    else if (width_reg == 64'd0)
                    begin
                        value_reg <= r_reg;
                    end
                    else
                    begin
                        value_reg <= lo_reg + rem_reg;
                    end
                end
                else if (kind_reg == xsr_pkg::REQ_FRAC)
                begin
                    value_reg <= r_reg >> xsr_pkg::FRACTION_SHIFT;
                end
                else
                begin
                    value_reg <= r_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.kind  = kind_reg;
    assign status.empty = empty_reg;
    assign status.full  = (width_reg == 64'd0);
    assign status.below = (r_reg < rem_reg);
    assign value        = value_reg;
    assign bad_range    = bad_reg;

endmodule
`default_nettype wire

// ===== src/xsr_ctrl.sv =====
// Controller state machine sequencing seed expansion and request service.
`default_nettype none
module xsr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire xsr_pkg::status_t status,
    output xsr_pkg::cmd_t         cmd
);

    xsr_pkg::state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == xsr_pkg::ST_IDLE);
    assign in_stall  = (state_reg != xsr_pkg::ST_IDLE) || cfg_valid;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xsr_pkg::ST_SEED;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xsr_pkg::ST_SEED:      state_next = xsr_pkg::ST_EXP_ADD;
            xsr_pkg::ST_EXP_ADD:   state_next = xsr_pkg::ST_MUL1;
            xsr_pkg::ST_MUL1:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = xsr_pkg::ST_EXP_X2;
                end
            end
            xsr_pkg::ST_EXP_X2:    state_next = xsr_pkg::ST_MUL2;
            xsr_pkg::ST_MUL2:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = xsr_pkg::ST_EXP_STORE;
                end
            end
            xsr_pkg::ST_EXP_STORE:
            begin
                state_next = (k_reg == 2'd3) ? xsr_pkg::ST_EXP_FIX : xsr_pkg::ST_EXP_ADD;
            end
            xsr_pkg::ST_EXP_FIX:   state_next = xsr_pkg::ST_IDLE;
            xsr_pkg::ST_IDLE:
            begin
                priority if (cfg_valid)
                begin
                    state_next = xsr_pkg::ST_SEED;
                end
                else if (in_valid)
                begin
                    state_next = xsr_pkg::ST_DECIDE;
                end
            end
            xsr_pkg::ST_DECIDE:
            begin
                priority if (status.kind == xsr_pkg::REQ_BOUNDED && status.empty)
                begin
                    state_next = xsr_pkg::ST_FINISH;
                end
                else if (status.kind == xsr_pkg::REQ_BOUNDED && !status.full)
                begin
                    state_next = xsr_pkg::ST_DISC_START;
                end
                else
                begin
                    state_next = xsr_pkg::ST_DRAW;
                end
            end
            xsr_pkg::ST_DRAW:       state_next = xsr_pkg::ST_FINISH;
            xsr_pkg::ST_DISC_START: state_next = xsr_pkg::ST_DISC_RUN;
            xsr_pkg::ST_DISC_RUN:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = xsr_pkg::ST_BDRAW;
                end
            end
            xsr_pkg::ST_BDRAW:      state_next = xsr_pkg::ST_BCHECK;
            xsr_pkg::ST_BCHECK:
            begin
                // A rejected draw is replaced by a fresh one.
                state_next = status.below ? xsr_pkg::ST_BDRAW : xsr_pkg::ST_MOD_RUN;
            end
            xsr_pkg::ST_MOD_RUN:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = xsr_pkg::ST_FINISH;
                end
            end
            xsr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = xsr_pkg::ST_IDLE;
                end
            end
            default:                state_next = xsr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '{op: xsr_pkg::OP_NONE, chunk: cnt_reg[1:0], word_sel: k_reg,
                           seed_we: 1'b0};
        cnt_next       = (state_next == state_reg) ? cnt_reg + 6'd1 : 6'd0;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            xsr_pkg::ST_SEED:
            begin
                cmd.op = xsr_pkg::OP_SEED_LOAD;
                k_next = 2'd0;
            end
            xsr_pkg::ST_EXP_ADD:   cmd.op = xsr_pkg::OP_EXP_ADD;
            xsr_pkg::ST_MUL1:      cmd.op = xsr_pkg::OP_MUL1;
            xsr_pkg::ST_EXP_X2:    cmd.op = xsr_pkg::OP_EXP_X2;
            xsr_pkg::ST_MUL2:      cmd.op = xsr_pkg::OP_MUL2;
            xsr_pkg::ST_EXP_STORE:
            begin
                cmd.op = xsr_pkg::OP_EXP_STORE;
                k_next = k_reg + 2'd1;
            end
            xsr_pkg::ST_EXP_FIX:   cmd.op = xsr_pkg::OP_EXP_FIX;
            xsr_pkg::ST_IDLE:
            begin
                priority if (cfg_valid)
                begin
                    cmd.seed_we = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.op = xsr_pkg::OP_LATCH;
                end
            end
            xsr_pkg::ST_DECIDE:     cmd.op = xsr_pkg::OP_NONE;
            xsr_pkg::ST_DRAW:       cmd.op = xsr_pkg::OP_DRAW;
            xsr_pkg::ST_DISC_START: cmd.op = xsr_pkg::OP_DIV_DISC;
            xsr_pkg::ST_DISC_RUN:   cmd.op = xsr_pkg::OP_DIV_STEP;
            xsr_pkg::ST_BDRAW:      cmd.op = xsr_pkg::OP_DRAW;
            xsr_pkg::ST_BCHECK:
            begin
                cmd.op = status.below ? xsr_pkg::OP_NONE : xsr_pkg::OP_DIV_MOD;
            end
            xsr_pkg::ST_MOD_RUN:    cmd.op = xsr_pkg::OP_DIV_STEP;
            xsr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op         = xsr_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                end
            end
            default:                cmd.op = xsr_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/xoshiro256pp_random_generator.sv =====
// Top level of the xoshiro256++ generator: controller plus datapath.
// Sequence: raw, fraction and full-range draws go from input transfer through decide, draw
// and finish; empty ranges go straight from decide to finish; other bounded draws also run
// two 64-step remainder passes, plus a draw and a check per rejected draw.
// Throughput: one request at a time; a result may wait in the output register while
// the next request is taken. Seed expansion runs on a shared 64x16 multiplier.
// After reset the seed-zero expansion runs first, with input and configuration held off.
`default_nettype none
module xoshiro256pp_random_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [63:0] range_min,
    input  wire logic [63:0] range_max,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value,
    output logic             bad_range,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] seed
);

    xsr_pkg::cmd_t    cmd;
    xsr_pkg::status_t status;

    xsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    xsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .seed      (seed),
        .req_type  (req_type),
        .range_min (range_min),
        .range_max (range_max),
        .status    (status),
        .value     (value),
        .bad_range (bad_range)
    );

endmodule
`default_nettype wire
